// File: rtl/dltq_pkg.sv
// shared types and constants for the delta-list timer queue
// used by dltq_ctrl, dltq_datapath and delta_list_timer_queue
package dltq_pkg;

	localparam int DLTQ_DEPTH_DEFAULT = 16;
	localparam int MAX_RESULTS        = 16;
	localparam logic [9:0] TICK_STEP_RESET = 10'd100;

	localparam logic [1:0] RK_INSERTED = 2'd0;
	localparam logic [1:0] RK_FULL     = 2'd1;
	localparam logic [1:0] RK_EXPIRED  = 2'd2;

	typedef struct packed {
		logic [23:0] delta;
		logic [7:0]  owner;
		logic [15:0] arg;
		logic [15:0] id;
	} entry_t;

	// datapath commands issued by the controller, one per cycle
	typedef enum logic [4:0] {
		OP_NONE,
		OP_ACCEPT,
		OP_RD_POS,
		OP_SPLIT,
		OP_ADV,
		OP_SH_INIT,
		OP_SH_RD,
		OP_SH_WR,
		OP_INS_DONE,
		OP_FULL,
		OP_HEAD_DEC,
		OP_HEAD_TAKE,
		OP_RD_N,
		OP_EXP_MID,
		OP_EXP_LAST,
		OP_CP_RD,
		OP_CP_WR,
		OP_CP_DONE
	} op_t;

	typedef struct packed {
		logic empty;
		logic full;
		logic pos_at_end;
		logic rem_lt;
		logic head_due;
		logic more;
		logic next_zero;
		logic sh_done;
		logic cp_end;
		logic out_free;
	} status_t;

endpackage

// File: rtl/dltq_ctrl.sv
// controller state machine of the delta-list timer queue
// depends on dltq_pkg; drives dltq_datapath through op_t commands
module dltq_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_kind,
	output logic             in_ready,
	input  dltq_pkg::status_t st,
	output dltq_pkg::op_t    op
);
	import dltq_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_INS_RD,
		S_INS_CMP,
		S_SHIFT,
		S_SH_WR,
		S_INS_DONE,
		S_FULL,
		S_TK_HEAD,
		S_TK_CHK,
		S_TK_NEXT,
		S_TK_LAST,
		S_CP_RD,
		S_CP_WR
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		op      = OP_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					op = OP_ACCEPT;
					if (in_kind) begin
						state_d = st.full ? S_FULL : S_INS_RD;
					end else begin
						state_d = st.empty ? S_IDLE : S_TK_HEAD;
					end
				end
			end
			S_INS_RD: begin
				if (st.pos_at_end) begin
					op      = OP_SH_INIT;
					state_d = S_SHIFT;
				end else begin
					op      = OP_RD_POS;
					state_d = S_INS_CMP;
				end
			end
			S_INS_CMP: begin
				if (st.rem_lt) begin
					op      = OP_SPLIT;
					state_d = S_SHIFT;
				end else begin
					op      = OP_ADV;
					state_d = S_INS_RD;
				end
			end
			S_SHIFT: begin
				if (st.sh_done) begin
					state_d = S_INS_DONE;
				end else begin
					op      = OP_SH_RD;
					state_d = S_SH_WR;
				end
			end
			S_SH_WR: begin
				op      = OP_SH_WR;
				state_d = S_SHIFT;
			end
			S_INS_DONE: begin
				if (st.out_free) begin
					op      = OP_INS_DONE;
					state_d = S_IDLE;
				end
			end
			S_FULL: begin
				if (st.out_free) begin
					op      = OP_FULL;
					state_d = S_IDLE;
				end
			end
			S_TK_HEAD: begin
				if (st.head_due) begin
					op      = OP_HEAD_TAKE;
					state_d = S_TK_CHK;
				end else begin
					op      = OP_HEAD_DEC;
					state_d = S_IDLE;
				end
			end
			S_TK_CHK: begin
				if (st.more) begin
					op      = OP_RD_N;
					state_d = S_TK_NEXT;
				end else begin
					state_d = S_TK_LAST;
				end
			end
			S_TK_NEXT: begin
				// a zero-delta follower expires with the head
				if (!st.next_zero) begin
					state_d = S_TK_LAST;
				end else if (st.out_free) begin
					op      = OP_EXP_MID;
					state_d = S_TK_CHK;
				end
			end
			S_TK_LAST: begin
				if (st.out_free) begin
					op      = OP_EXP_LAST;
					state_d = S_CP_RD;
				end
			end
			S_CP_RD: begin
				if (st.cp_end) begin
					op      = OP_CP_DONE;
					state_d = S_IDLE;
				end else begin
					op      = OP_CP_RD;
					state_d = S_CP_WR;
				end
			end
			S_CP_WR: begin
				op      = OP_CP_WR;
				state_d = S_CP_RD;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: rtl/dltq_datapath.sv
// datapath of the delta-list timer queue: entry memory, walk counters,
// tick step register and result register; depends on dltq_pkg
module dltq_datapath #(
	parameter int QUEUE_DEPTH = dltq_pkg::DLTQ_DEPTH_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  dltq_pkg::op_t     op,
	input  logic [7:0]        in_owner_id,
	input  logic [23:0]       in_wait_time,
	input  logic [15:0]       in_callback_arg,
	input  logic              cfg_valid,
	input  logic [9:0]        cfg_data,
	output dltq_pkg::status_t st,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        out_result_kind,
	output logic [15:0]       out_timer_id,
	output logic [7:0]        out_expired_owner,
	output logic [15:0]       out_expired_arg,
	output logic              out_last_of_run
);
	import dltq_pkg::*;

	localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CW-1:0] DepthC = CW'(QUEUE_DEPTH);

	entry_t mem_q [QUEUE_DEPTH];
	entry_t rd_q;
	entry_t cur_q;
	entry_t wr_data;
	logic          wr_en, rd_en;
	logic [IW-1:0] wr_addr, rd_addr;

	logic [CW-1:0] count_q;
	logic [15:0]   next_id_q;
	logic [9:0]    step_q;
	logic [CW-1:0] pos_q, j_q, n_q;
	logic [23:0]   remain_q;
	logic [7:0]    owner_q;
	logic [15:0]   arg_q;

	logic [CW-1:0] j_m1, j_mn;
	logic          push;
	logic [1:0]    push_kind;
	logic [15:0]   push_id;
	logic [7:0]    push_owner;
	logic [15:0]   push_arg;
	logic          push_last;

	assign j_m1 = j_q - 1'b1;
	assign j_mn = j_q - n_q;

	assign st.empty      = (count_q == '0);
	assign st.full       = (count_q == DepthC);
	assign st.pos_at_end = (pos_q == count_q);
	assign st.rem_lt     = (remain_q < rd_q.delta);
	assign st.head_due   = (rd_q.delta <= {14'd0, step_q});
	assign st.more       = (n_q < count_q) && (32'(n_q) < MAX_RESULTS);
	assign st.next_zero  = (rd_q.delta == 24'd0);
	assign st.sh_done    = (j_q == pos_q);
	assign st.cp_end     = (j_q == count_q);
	assign st.out_free   = !out_valid || out_ready;

	// memory port selection
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = rd_q;
		rd_en   = 1'b0;
		rd_addr = '0;
		unique case (op)
			OP_ACCEPT: begin
				rd_en = 1'b1;
			end
			OP_RD_POS: begin
				rd_en   = 1'b1;
				rd_addr = pos_q[IW-1:0];
			end
			OP_SPLIT: begin
				wr_en         = 1'b1;
				wr_addr       = pos_q[IW-1:0];
				wr_data.delta = rd_q.delta - remain_q;
			end
			OP_SH_RD: begin
				rd_en   = 1'b1;
				rd_addr = j_m1[IW-1:0];
			end
			OP_SH_WR: begin
				wr_en   = 1'b1;
				wr_addr = j_q[IW-1:0];
			end
			OP_INS_DONE: begin
				wr_en         = 1'b1;
				wr_addr       = pos_q[IW-1:0];
				wr_data.delta = remain_q;
				wr_data.owner = owner_q;
				wr_data.arg   = arg_q;
				wr_data.id    = next_id_q;
			end
			OP_HEAD_DEC: begin
				wr_en         = 1'b1;
				wr_data.delta = rd_q.delta - {14'd0, step_q};
			end
			OP_RD_N: begin
				rd_en   = 1'b1;
				rd_addr = n_q[IW-1:0];
			end
			OP_CP_RD: begin
				rd_en   = 1'b1;
				rd_addr = j_q[IW-1:0];
			end
			OP_CP_WR: begin
				wr_en   = 1'b1;
				wr_addr = j_mn[IW-1:0];
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	// result selection
	always_comb begin
		push       = 1'b0;
		push_kind  = RK_EXPIRED;
		push_id    = cur_q.id;
		push_owner = cur_q.owner;
		push_arg   = cur_q.arg;
		push_last  = 1'b0;
		unique case (op)
			OP_INS_DONE: begin
				push       = 1'b1;
				push_kind  = RK_INSERTED;
				push_id    = next_id_q;
				push_owner = 8'd0;
				push_arg   = 16'd0;
				push_last  = 1'b1;
			end
			OP_FULL: begin
				push       = 1'b1;
				push_kind  = RK_FULL;
				push_id    = 16'd0;
				push_owner = 8'd0;
				push_arg   = 16'd0;
				push_last  = 1'b1;
			end
			OP_EXP_MID: begin
				push = 1'b1;
			end
			OP_EXP_LAST: begin
				push      = 1'b1;
				push_last = 1'b1;
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			next_id_q <= 16'd0;
			step_q    <= TICK_STEP_RESET;
			out_valid <= 1'b0;
		end else begin
			if (cfg_valid) begin
				step_q <= cfg_data;
			end
			if (op == OP_INS_DONE) begin
				count_q   <= count_q + 1'b1;
				next_id_q <= next_id_q + 16'd1;
			end else if (op == OP_CP_DONE) begin
				count_q <= count_q - n_q;
			end
			if (push) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_result_kind   <= push_kind;
			out_timer_id      <= push_id;
			out_expired_owner <= push_owner;
			out_expired_arg   <= push_arg;
			out_last_of_run   <= push_last;
		end
		unique case (op)
			OP_ACCEPT: begin
				pos_q    <= '0;
				remain_q <= in_wait_time;
				owner_q  <= in_owner_id;
				arg_q    <= in_callback_arg;
			end
			OP_ADV: begin
				remain_q <= remain_q - rd_q.delta;
				pos_q    <= pos_q + 1'b1;
			end
			OP_SPLIT, OP_SH_INIT: begin
				j_q <= count_q;
			end
			OP_SH_WR: begin
				j_q <= j_m1;
			end
			OP_HEAD_TAKE: begin
				cur_q <= rd_q;
				n_q   <= CW'(1);
			end
			OP_EXP_MID: begin
				cur_q <= rd_q;
				n_q   <= n_q + 1'b1;
			end
			OP_EXP_LAST: begin
				j_q <= n_q;
			end
			OP_CP_WR: begin
				j_q <= j_q + 1'b1;
			end
			default: begin
				j_q <= j_q;
			end
		endcase
	end

endmodule

// File: rtl/delta_list_timer_queue.sv
// delta-list timer queue, top level
// instantiates dltq_ctrl and dltq_datapath; depends on dltq_pkg
//
// usage: s_axis carries one request per item, tuser selects a tick (0) or
// an insert (1). an insert answers with one result: inserted with its timer
// id, or rejected when the queue is full. a tick counts the head entry down
// by tick_step; when the head falls due it expires with any zero-delta
// entries behind it (at most sixteen in all), one result each, tlast on
// the final one. a tick that expires nothing gives no result.
// cfg_* writes tick_step; it is taken at any time but should only change
// while the queue is idle.
// timing: one request at a time. the entry store has one registered read
// port, so the walk reads each entry before it compares or moves it. an
// insert walks the list to its place and shifts the entries behind it up;
// a tick with expiries reads the due entries and then shifts the rest down.
// results sit in an output register; a stalled m_axis holds the walk at the
// next result, and a new request is taken while the last result waits.
// reset empties the queue, zeroes the id counter and sets tick_step to 100;
// no clearing pass is needed.
module delta_list_timer_queue #(
	parameter int QUEUE_DEPTH = dltq_pkg::DLTQ_DEPTH_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // owner_id, wait_time, callback_arg
	input  logic        s_axis_tuser,  // kind
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // timer_id, expired_owner, expired_arg
	output logic [1:0]  m_axis_tuser,  // result_kind
	output logic        m_axis_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [9:0]  cfg_data
);
	import dltq_pkg::*;

	op_t     op;
	status_t st;
	logic [15:0] timer_id;
	logic [7:0]  expired_owner;
	logic [15:0] expired_arg;

	assign cfg_ready    = 1'b1;
	assign m_axis_tdata = {expired_arg, expired_owner, timer_id};

	dltq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_kind  (s_axis_tuser),
		.in_ready (s_axis_tready),
		.st       (st),
		.op       (op)
	);

	dltq_datapath #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.op                (op),
		.in_owner_id       (s_axis_tdata[7:0]),
		.in_wait_time      (s_axis_tdata[31:8]),
		.in_callback_arg   (s_axis_tdata[47:32]),
		.cfg_valid         (cfg_valid),
		.cfg_data          (cfg_data),
		.st                (st),
		.out_valid         (m_axis_tvalid),
		.out_ready         (m_axis_tready),
		.out_result_kind   (m_axis_tuser),
		.out_timer_id      (timer_id),
		.out_expired_owner (expired_owner),
		.out_expired_arg   (expired_arg),
		.out_last_of_run   (m_axis_tlast)
	);

endmodule

// File: bench/delta_list_timer_queue_tb.sv
// self-checking bench for the delta-list timer queue top level
// predicts every result from its own copy of the timer list; needs dltq_pkg and the rtl
`timescale 1ns / 100ps

module delta_list_timer_queue_tb;
	import dltq_pkg::*;

	localparam int QDEPTH = DLTQ_DEPTH_DEFAULT;
	localparam logic KIND_TICK = 1'b0;
	localparam logic KIND_INSERT = 1'b1;
	localparam int SETTLE_CYCLES = 60;
	localparam int SQUEEZE_CYCLES = 300;
	localparam int STALL_LIMIT = 4000;
	localparam int PLAN_ROWS = 26;
	localparam int PHASES = 5;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] id;
		logic [7:0]  owner;
		logic [15:0] arg;
		logic        last;
	} answer_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  owner;
		logic [23:0] span;
		logic [15:0] arg;
		logic        typed;
		answer_t     ans;
	} plan_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata = '0;   // owner_id, wait_time, callback_arg
	logic        s_axis_tuser = 1'b0; // kind
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;        // timer_id, expired_owner, expired_arg
	logic [1:0]  m_axis_tuser;        // result_kind
	logic        m_axis_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [9:0]  cfg_data = '0;

	// shadow of the timer list
	entry_t      slots [QDEPTH];
	int unsigned fill = 0;
	logic [15:0] id_ctr = '0;
	logic [9:0]  step_now = TICK_STEP_RESET;

	answer_t     awaited [$];
	answer_t     head_ans;
	plan_row_t   plan [PLAN_ROWS];

	bit          no_gaps = 1'b0;
	bit          squeeze_req = 1'b0;
	int unsigned fail_count = 0;
	int unsigned results_seen = 0;
	int unsigned n_inserts = 0;
	int unsigned n_ticks = 0;
	int unsigned n_settings = 0;
	int unsigned idle_cycles = 0;

	delta_list_timer_queue dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	function automatic answer_t mk_answer(input logic [1:0] kind, input logic [15:0] id,
			input logic [7:0] owner, input logic [15:0] arg, input logic last);
		answer_t a;
		a.kind = kind;
		a.id = id;
		a.owner = owner;
		a.arg = arg;
		a.last = last;
		return a;
	endfunction

	function automatic plan_row_t mk_row(input logic kind, input logic [7:0] owner,
			input logic [23:0] span, input logic [15:0] arg, input logic typed,
			input logic [1:0] rk, input logic [15:0] rid);
		plan_row_t r;
		r.kind = kind;
		r.owner = owner;
		r.span = span;
		r.arg = arg;
		r.typed = typed;
		r.ans = mk_answer(rk, rid, 8'd0, 16'd0, 1'b1);
		return r;
	endfunction

	function automatic int pick_gap();
		if (no_gaps || $urandom_range(0, 3) == 0)
			return 0;
		return $urandom_range(0, 18);
	endfunction

	// appends one expected result at the tail of the awaited list
	function automatic void expect_answer(input answer_t a);
		awaited = {awaited, a};
	endfunction

	// walks the shadow list for one request and queues the results it causes
	function automatic void advance_timers(input logic kind, input logic [7:0] owner,
			input logic [23:0] span, input logic [15:0] arg);
		int unsigned pos;
		int unsigned j;
		int unsigned n;
		logic [23:0] remain;
		bit placed;
		answer_t a;
		if (kind == KIND_INSERT) begin
			if (fill >= QDEPTH) begin
				expect_answer(mk_answer(RK_FULL, 16'd0, 8'd0, 16'd0, 1'b1));
				return;
			end
			pos = 0;
			remain = span;
			placed = 1'b0;
			// an equal delta does not stop the walk, so equal deadlines keep insert order
			while (pos < fill && !placed) begin
				if (remain < slots[pos].delta) begin
					slots[pos].delta = slots[pos].delta - remain;
					placed = 1'b1;
				end else begin
					remain = remain - slots[pos].delta;
					pos++;
				end
			end
			for (j = fill; j > pos; j--)
				slots[j] = slots[j - 1];
			slots[pos].delta = remain;
			slots[pos].owner = owner;
			slots[pos].arg = arg;
			slots[pos].id = id_ctr;
			fill++;
			expect_answer(mk_answer(RK_INSERTED, id_ctr, 8'd0, 16'd0, 1'b1));
			id_ctr = id_ctr + 16'd1;
			return;
		end
		if (fill == 0)
			return;
		if (slots[0].delta > {14'd0, step_now}) begin
			slots[0].delta = slots[0].delta - {14'd0, step_now};
			return;
		end
		// head is due: it goes, and so do the zero-delta entries right behind it, up to MAX_RESULTS in all
		n = 0;
		do begin
			a = mk_answer(RK_EXPIRED, slots[n].id, slots[n].owner, slots[n].arg, 1'b0);
			n++;
			a.last = !(n < fill && n < MAX_RESULTS && slots[n].delta == 24'd0);
			expect_answer(a);
		end while (!a.last);
		for (j = n; j < fill; j++)
			slots[j - n] = slots[j];
		fill = fill - n;
	endfunction

	task automatic offer_request(input logic kind, input logic [7:0] owner,
			input logic [23:0] span, input logic [15:0] arg, input logic typed,
			input answer_t typed_ans);
		int gap;
		int before_cnt;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= kind;
		s_axis_tdata <= {arg, span, owner};
		do @(posedge clk); while (!s_axis_tready);
		before_cnt = awaited.size();
		advance_timers(kind, owner, span, arg);
		if (typed) begin
			while (awaited.size() > before_cnt)
				void'(awaited.pop_back());
			expect_answer(typed_ans);
		end
		if (kind == KIND_INSERT)
			n_inserts++;
		else
			n_ticks++;
	endtask

	// lets the queue run dry and the walk finish before anything else happens
	task automatic drain_queue();
		s_axis_tvalid <= 1'b0;
		while (awaited.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_tick_step(input logic [9:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		step_now = value;
		n_settings++;
	endtask

	// result side: random back-pressure, plus one long hold-off on request
	initial begin
		int gap;
		wait (arst_n === 1'b1);
		forever begin
			gap = pick_gap();
			if (squeeze_req) begin
				squeeze_req = 1'b0;
				gap = SQUEEZE_CYCLES;
			end
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_seen++;
			if (awaited.size() == 0) begin
				$error("unexpected result: result_kind %0d timer_id %0d", m_axis_tuser,
					m_axis_tdata[15:0]);
				fail_count++;
			end else begin
				head_ans = awaited.pop_front();
				if (m_axis_tuser !== head_ans.kind) begin
					$error("result_kind: expected %0d, got %0d", head_ans.kind, m_axis_tuser);
					fail_count++;
				end
				if (m_axis_tdata[15:0] !== head_ans.id) begin
					$error("timer_id: expected %0d, got %0d", head_ans.id, m_axis_tdata[15:0]);
					fail_count++;
				end
				if (m_axis_tdata[23:16] !== head_ans.owner) begin
					$error("expired_owner: expected %0d, got %0d", head_ans.owner,
						m_axis_tdata[23:16]);
					fail_count++;
				end
				if (m_axis_tdata[39:24] !== head_ans.arg) begin
					$error("expired_arg: expected %0d, got %0d", head_ans.arg,
						m_axis_tdata[39:24]);
					fail_count++;
				end
				if (m_axis_tlast !== head_ans.last) begin
					$error("last_of_run: expected %0d, got %0d", head_ans.last, m_axis_tlast);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == STALL_LIMIT) begin
			$display("timeout: no request moved for %0d cycles", STALL_LIMIT);
			$display("delta_list_timer_queue regression: fail");
			$finish;
		end
	end

	initial begin
		int i;
		int p;
		int k;
		int mode;
		logic kind;
		logic [7:0] owner;
		logic [23:0] span;
		logic [15:0] arg;
		logic [9:0] step_plan [PHASES];
		int items_plan [PHASES];

		// directed: empty tick, field extremes, equal deadlines, fill to full, long burst
		plan[0] = mk_row(KIND_TICK, 8'h00, 24'd0, 16'h0000, 1'b0, RK_INSERTED, 16'd0);
		plan[1] = mk_row(KIND_INSERT, 8'hFF, 24'd0, 16'hFFFF, 1'b1, RK_INSERTED, 16'd0);
		plan[2] = mk_row(KIND_INSERT, 8'h00, 24'hFFFFFF, 16'h0000, 1'b1, RK_INSERTED, 16'd1);
		plan[3] = mk_row(KIND_INSERT, 8'h5A, 24'd0, 16'h1234, 1'b1, RK_INSERTED, 16'd2);
		plan[4] = mk_row(KIND_TICK, 8'hFF, 24'hFFFFFF, 16'hFFFF, 1'b0, RK_INSERTED, 16'd0);
		plan[5] = mk_row(KIND_INSERT, 8'h3C, 24'd200, 16'hABCD, 1'b0, RK_INSERTED, 16'd0);
		plan[6] = mk_row(KIND_INSERT, 8'hC3, 24'd200, 16'h5555, 1'b0, RK_INSERTED, 16'd0);
		plan[7] = mk_row(KIND_TICK, 8'h00, 24'd0, 16'h0000, 1'b0, RK_INSERTED, 16'd0);
		plan[8] = mk_row(KIND_TICK, 8'h00, 24'd0, 16'h0000, 1'b0, RK_INSERTED, 16'd0);
		for (i = 0; i < 15; i++)
			plan[9 + i] = mk_row(KIND_INSERT, 8'h10 + i[7:0], 24'd0, {i[7:0], 8'hA0},
				1'b0, RK_INSERTED, 16'd0);
		plan[24] = mk_row(KIND_INSERT, 8'hFF, 24'hFFFFFF, 16'hFFFF, 1'b1, RK_FULL, 16'd0);
		plan[25] = mk_row(KIND_TICK, 8'h00, 24'd0, 16'h0000, 1'b0, RK_INSERTED, 16'd0);

		step_plan[0] = 10'd1023;
		step_plan[1] = 10'd1;
		step_plan[2] = 10'd0;
		step_plan[3] = 10'($urandom_range(2, 1022));
		step_plan[4] = 10'd1023;
		items_plan[0] = 24;
		items_plan[1] = 24;
		items_plan[2] = 12;
		items_plan[3] = 24;
		items_plan[4] = 24;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < PLAN_ROWS; i++)
			offer_request(plan[i].kind, plan[i].owner, plan[i].span, plan[i].arg,
				plan[i].typed, plan[i].ans);

		for (p = 0; p < PHASES; p++) begin
			drain_queue();
			write_tick_step(step_plan[p]);
			no_gaps = (p == 1 || p == 3);
			// the receiver stalls long enough here for the input to back up
			if (p == 3)
				squeeze_req = 1'b1;
			for (k = 0; k < items_plan[p]; k++) begin
				kind = ($urandom_range(0, 99) < 45) ? KIND_TICK : KIND_INSERT;
				owner = 8'($urandom);
				arg = 16'($urandom);
				mode = $urandom_range(0, 99);
				if (mode < 15)
					span = 24'd0;
				else if (mode < 20)
					span = 24'($urandom);
				else if (mode < 40)
					span = 24'(int'(step_now) * $urandom_range(1, 3));
				else
					span = 24'($urandom_range(0, 4 * int'(step_now) + 4));
				offer_request(kind, owner, span, arg, 1'b0, '0);
			end
		end

		drain_queue();
		$display("covered %0d inserts and %0d ticks, %0d results checked", n_inserts,
			n_ticks, results_seen);
		$display("tick_step written %0d times, 0 and 1023 included, one long output stall",
			n_settings);
		if (fail_count == 0)
			$display("delta_list_timer_queue regression: pass");
		else
			$display("delta_list_timer_queue regression: fail");
		$finish;
	end

endmodule

// File: sim.f
rtl/dltq_pkg.sv
rtl/dltq_ctrl.sv
rtl/dltq_datapath.sv
rtl/delta_list_timer_queue.sv
bench/delta_list_timer_queue_tb.sv
